@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
// Every check is sampled on the rising edge of clk and is held off while
// rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that holds in the same cycle.
`define NPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a condition that must hold in the cycle after a trigger.
`define NPR_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ src/npr_pkg.sv @@
// ----------------------------------------------------------------------------
// npr_pkg
// Types and constants for the NAND page read sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package npr_pkg;

  localparam int unsigned PAGE_BYTES = 2048;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned STEP_W     = 4;

  localparam logic [7:0] NAND_READ0 = 8'h00;
  localparam logic [7:0] NAND_READ1 = 8'h30;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_READY = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_READ = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ACT_SELECT   = 3'd0,
    ACT_CMD      = 3'd1,
    ACT_ADDR     = 3'd2,
    ACT_AWAIT    = 3'd3,
    ACT_STROBE   = 3'd4,
    ACT_DATA     = 3'd5,
    ACT_DESELECT = 3'd6
  } act_t;

  // Result sequence caused by one request
  typedef enum logic [2:0] {
    SEQ_START_EMPTY = 3'd0,  // select, deselect
    SEQ_START       = 3'd1,  // select, page setup
    SEQ_STROBE      = 3'd2,  // read strobe
    SEQ_DATA_DESEL  = 3'd3,  // data byte, deselect
    SEQ_DATA_SETUP  = 3'd4,  // data byte, page setup
    SEQ_DATA_STROBE = 3'd5   // data byte, read strobe
  } seq_t;

  typedef struct packed {
    seq_t              kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] index;
    logic [7:0]        col_lo;
    logic [7:0]        col_hi;
    logic [7:0]        pg0;
    logic [7:0]        pg1;
    logic [7:0]        pg2;
  } desc_t;

  function automatic logic [STEP_W-1:0] last_step(seq_t kind);
    logic [STEP_W-1:0] s;
    unique case (kind)
      SEQ_START_EMPTY: s = STEP_W'(1);
      SEQ_START:       s = STEP_W'(8);
      SEQ_STROBE:      s = STEP_W'(0);
      SEQ_DATA_DESEL:  s = STEP_W'(1);
      SEQ_DATA_SETUP:  s = STEP_W'(8);
      SEQ_DATA_STROBE: s = STEP_W'(1);
      default:         s = STEP_W'(0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/npr_if.sv @@
// ----------------------------------------------------------------------------
// npr_in_if / npr_out_if
// Valid/ready channels for requests and results of the page read sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface npr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] start_address;
  logic [31:0] byte_count;
  logic        ready_bit;
  logic [7:0]  flash_byte;

  modport source (output valid, cmd, start_address, byte_count, ready_bit, flash_byte,
                  input ready);
  modport sink   (input valid, cmd, start_address, byte_count, ready_bit, flash_byte,
                  output ready);
endinterface

interface npr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  bus_value;
  logic [31:0] dest_index;
  logic        last_of_run;

  modport source (output valid, action, bus_value, dest_index, last_of_run, input ready);
  modport sink   (input valid, action, bus_value, dest_index, last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/npr_step.sv @@
// ----------------------------------------------------------------------------
// npr_step
// Request decoder and sequencer state: phase, flash address, byte counts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module npr_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  npr_in_if.sink              in_req,
  input  wire logic           desc_ready,
  output logic                desc_load,
  output npr_pkg::desc_t      desc
);
  import npr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   done_r, done_nxt;
  logic [ADDR_W-1:0]   wanted_r, wanted_nxt;

  logic                accept;
  logic [ADDR_W-1:0]   addr_inc;
  logic [ADDR_W-1:0]   done_inc;
  logic                run_done;
  logic                page_wrap;
  logic                start_ok;
  logic                ready_ok;
  logic                data_ok;
  logic [ADDR_W-1:0]   sel_addr;
  logic [ADDR_W-1:0]   col;
  logic [ADDR_W-1:0]   page;

  assign in_req.ready = desc_ready;
  assign accept       = in_req.valid && desc_ready;

  assign addr_inc  = addr_r + ADDR_W'(1);
  assign done_inc  = done_r + ADDR_W'(1);
  assign run_done  = (done_inc == wanted_r);
  assign page_wrap = (addr_inc[PAGE_SHIFT-1:0] == '0);

  assign start_ok = accept && (in_req.cmd == CMD_START)
                    && (phase_r != PH_WAIT) && (phase_r != PH_READ);
  assign ready_ok = accept && (in_req.cmd == CMD_READY)
                    && (phase_r == PH_WAIT) && in_req.ready_bit;
  assign data_ok  = accept && (in_req.cmd == CMD_DATA) && (phase_r == PH_READ);

  // Column and page bytes of the start address or of the next byte's address
  assign sel_addr = (in_req.cmd == CMD_START) ? in_req.start_address : addr_inc;
  assign col      = sel_addr & ADDR_W'(PAGE_BYTES - 1);
  assign page     = sel_addr >> PAGE_SHIFT;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_ok && (in_req.byte_count != '0)) phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        if (ready_ok) phase_nxt = PH_READ;
      end
      PH_READ: begin
        if (data_ok) begin
          if (run_done)       phase_nxt = PH_IDLE;
          else if (page_wrap) phase_nxt = PH_WAIT;
        end
      end
      default: begin
        if (start_ok && (in_req.byte_count != '0)) phase_nxt = PH_WAIT;
        else                                        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result sequence and counters
  always_comb begin
    addr_nxt    = addr_r;
    done_nxt    = done_r;
    wanted_nxt  = wanted_r;
    desc_load   = 1'b0;
    desc.kind   = SEQ_STROBE;
    desc.data   = in_req.flash_byte;
    desc.index  = done_r;
    desc.col_lo = col[7:0];
    desc.col_hi = col[15:8];
    desc.pg0    = page[7:0];
    desc.pg1    = page[15:8];
    desc.pg2    = page[23:16];
    if (start_ok) begin
      desc_load  = 1'b1;
      addr_nxt   = in_req.start_address;
      wanted_nxt = in_req.byte_count;
      done_nxt   = '0;
      desc.kind  = (in_req.byte_count == '0) ? SEQ_START_EMPTY : SEQ_START;
    end else if (ready_ok) begin
      desc_load = 1'b1;
      desc.kind = SEQ_STROBE;
    end else if (data_ok) begin
      desc_load = 1'b1;
      addr_nxt  = addr_inc;
      done_nxt  = done_inc;
      if (run_done)       desc.kind = SEQ_DATA_DESEL;
      else if (page_wrap) desc.kind = SEQ_DATA_SETUP;
      else                desc.kind = SEQ_DATA_STROBE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      addr_r   <= '0;
      done_r   <= '0;
      wanted_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      done_r   <= done_nxt;
      wanted_r <= wanted_nxt;
    end
  end

  `NPR_ASSERT(a_run_open, (phase_r == PH_IDLE) || (done_r < wanted_r), "active run has no bytes left")
  `NPR_ASSERT_NEXT(a_strobe_reads, ready_ok, phase_r == PH_READ, "ready sample did not start reading")

endmodule

`default_nettype wire

@@ src/npr_emit.sv @@
// ----------------------------------------------------------------------------
// npr_emit
// Steps through the results of one request and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module npr_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           desc_load,
  input  wire npr_pkg::desc_t desc,
  output logic                desc_ready,
  npr_out_if.source           out_res
);
  import npr_pkg::*;

  desc_t              desc_r;
  logic               desc_v_r, desc_v_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W-1:0]  step_end;
  logic               is_last;
  logic               emit_fire;

  logic               out_valid_r, out_valid_nxt;
  act_t               out_act_r;
  logic [7:0]         out_val_r;
  logic [ADDR_W-1:0]  out_idx_r;
  logic               out_last_r;

  act_t               res_act;
  logic [7:0]         res_val;
  logic [ADDR_W-1:0]  res_idx;

  assign step_end   = last_step(desc_r.kind);
  assign is_last    = (step_r == step_end);
  assign emit_fire  = desc_v_r && (!out_valid_r || out_res.ready);
  assign desc_ready = !desc_v_r || (emit_fire && is_last);

  always_comb begin
    desc_v_nxt = desc_v_r;
    step_nxt   = step_r;
    if (desc_load) begin
      desc_v_nxt = 1'b1;
      step_nxt   = '0;
    end else if (emit_fire && is_last) begin
      desc_v_nxt = 1'b0;
    end else if (emit_fire) begin
      step_nxt   = step_r + STEP_W'(1);
    end
    if (emit_fire)          out_valid_nxt = 1'b1;
    else if (out_res.ready) out_valid_nxt = 1'b0;
    else                    out_valid_nxt = out_valid_r;
  end

  // Result at the current step
  always_comb begin
    res_act = ACT_SELECT;
    res_val = '0;
    res_idx = '0;
    if (step_r == '0) begin
      case (desc_r.kind)
        SEQ_START_EMPTY, SEQ_START: res_act = ACT_SELECT;
        SEQ_STROBE:                 res_act = ACT_STROBE;
        default: begin
          res_act = ACT_DATA;
          res_val = desc_r.data;
          res_idx = desc_r.index;
        end
      endcase
    end else if (desc_r.kind == SEQ_START_EMPTY || desc_r.kind == SEQ_DATA_DESEL) begin
      res_act = ACT_DESELECT;
    end else if (desc_r.kind == SEQ_DATA_STROBE) begin
      res_act = ACT_STROBE;
    end else begin
      case (step_r)
        STEP_W'(1): begin res_act = ACT_CMD;  res_val = NAND_READ0;    end
        STEP_W'(2): begin res_act = ACT_ADDR; res_val = desc_r.col_lo; end
        STEP_W'(3): begin res_act = ACT_ADDR; res_val = desc_r.col_hi; end
        STEP_W'(4): begin res_act = ACT_ADDR; res_val = desc_r.pg0;    end
        STEP_W'(5): begin res_act = ACT_ADDR; res_val = desc_r.pg1;    end
        STEP_W'(6): begin res_act = ACT_ADDR; res_val = desc_r.pg2;    end
        STEP_W'(7): begin res_act = ACT_CMD;  res_val = NAND_READ1;    end
        default:    res_act = ACT_AWAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_v_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      desc_v_r    <= desc_v_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_load) desc_r <= desc;
    if (emit_fire) begin
      out_act_r  <= res_act;
      out_val_r  <= res_val;
      out_idx_r  <= res_idx;
      out_last_r <= is_last;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.action      = out_act_r;
  assign out_res.bus_value   = out_val_r;
  assign out_res.dest_index  = out_idx_r;
  assign out_res.last_of_run = out_last_r;

  `NPR_ASSERT(a_step_range, !desc_v_r || (step_r <= step_end), "step past end of sequence")
  `NPR_ASSERT_NEXT(a_load_free, desc_load, desc_v_r && (step_r == '0), "request not loaded at step zero")
  `NPR_ASSERT_NEXT(a_emit_shown, emit_fire, out_valid_r, "emitted result not held for output")

endmodule

`default_nettype wire

@@ src/nand_page_read_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// nand_page_read_sequencer_top
// Large-page NAND read sequencer: select, 0x00, five address bytes, 0x30,
// await ready, then strobe and deliver bytes, re-addressing at each page.
// ----------------------------------------------------------------------------
//  port     | dir | carries
//  ---------+-----+--------------------------------------------------------
//  in_req   | in  | cmd, start_address, byte_count, ready_bit, flash_byte
//  out_res  | out | action, bus_value, dest_index, last_of_run
//
//  A request causes 1 to 9 results, and the output register is loaded
//  with one result per cycle while the output is not stalled. A request
//  with no results is accepted without loading a sequence.
//  The next request is taken in the cycle the last result of the previous
//  one enters the output register.
//  A stalled output holds its register and the pending sequence.
//  Reset (rst_n low, synchronous) returns to idle with no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module nand_page_read_sequencer_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  npr_in_if.sink     in_req,
  npr_out_if.source  out_res
);
  import npr_pkg::*;

  logic   desc_load;
  logic   desc_ready;
  desc_t  desc;

  npr_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .desc_ready (desc_ready),
    .desc_load  (desc_load),
    .desc       (desc)
  );

  npr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_load  (desc_load),
    .desc       (desc),
    .desc_ready (desc_ready),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the NAND page read sequencer against a cycle-free prediction of its
// result stream: select, read command, address bytes, confirm, await ready,
// strobes, delivered bytes, re-addressing at page ends and deselect.
// Opening table rows come first, then random read runs mixed with stray and
// ignored requests, with random idling on both channels, then closing rows.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import npr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int OPEN_ROWS     = 19;
  localparam int RAND_ITEMS    = 64;
  localparam int CALM_AFTER    = 50;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] count;
    logic        rdy;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    act_t        action;
    logic [7:0]  value;
    logic [31:0] index;
    logic        last;
  } res_t;

  // n_typed < 0: results come from the predictor; otherwise they are typed in
  typedef struct packed {
    req_t        req;
    int          n_typed;
    act_t        a0;
    logic [7:0]  v0;
    logic [31:0] i0;
    act_t        a1;
  } row_t;

  logic clk;
  logic rst_n;

  npr_in_if  in_req();
  npr_out_if out_res();

  nand_page_read_sequencer_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // Predicted read state
  phase_t      rd_phase  = PH_IDLE;
  logic [31:0] rd_addr   = '0;
  logic [31:0] rd_done   = '0;
  logic [31:0] rd_wanted = '0;

  res_t step_actions[$];
  res_t awaited_actions[$];
  int   errors = 0;
  bit   calm   = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("[nand_page_read_sequencer_top] ERROR");
    $finish;
  end

  function automatic void add_action(act_t a, logic [7:0] v, logic [31:0] i);
    res_t r;
    r.action = a;
    r.value  = v;
    r.index  = i;
    r.last   = 1'b0;
    step_actions.push_back(r);
  endfunction

  function automatic void close_step();
    res_t r;
    if (step_actions.size() > 0) begin
      r = step_actions.pop_back();
      r.last = 1'b1;
      step_actions.push_back(r);
    end
  endfunction

  function automatic void add_page_setup();
    logic [31:0] col;
    logic [31:0] pg;
    col = rd_addr % PAGE_BYTES;
    pg  = rd_addr / PAGE_BYTES;
    add_action(ACT_CMD, NAND_READ0, 32'd0);
    add_action(ACT_ADDR, col[7:0], 32'd0);
    add_action(ACT_ADDR, col[15:8], 32'd0);
    add_action(ACT_ADDR, pg[7:0], 32'd0);
    add_action(ACT_ADDR, pg[15:8], 32'd0);
    add_action(ACT_ADDR, pg[23:16], 32'd0);
    add_action(ACT_CMD, NAND_READ1, 32'd0);
    add_action(ACT_AWAIT, 8'h00, 32'd0);
  endfunction

  function automatic void predict_actions(req_t r);
    step_actions.delete();
    case (r.cmd)
      CMD_START: begin
        if (rd_phase != PH_WAIT && rd_phase != PH_READ) begin
          rd_addr   = r.addr;
          rd_wanted = r.count;
          rd_done   = '0;
          add_action(ACT_SELECT, 8'h00, 32'd0);
          if (rd_wanted == 0) begin
            add_action(ACT_DESELECT, 8'h00, 32'd0);
            rd_phase = PH_IDLE;
          end else begin
            add_page_setup();
            rd_phase = PH_WAIT;
          end
        end
      end
      CMD_READY: begin
        if (rd_phase == PH_WAIT && r.rdy) begin
          rd_phase = PH_READ;
          add_action(ACT_STROBE, 8'h00, 32'd0);
        end
      end
      CMD_DATA: begin
        if (rd_phase == PH_READ) begin
          add_action(ACT_DATA, r.data, rd_done);
          rd_done = rd_done + 1;
          rd_addr = rd_addr + 1;
          if (rd_done == rd_wanted) begin
            add_action(ACT_DESELECT, 8'h00, 32'd0);
            rd_phase = PH_IDLE;
          end else if (rd_addr % PAGE_BYTES == 0) begin
            add_page_setup();
            rd_phase = PH_WAIT;
          end else begin
            add_action(ACT_STROBE, 8'h00, 32'd0);
          end
        end
      end
      default: ;
    endcase
    close_step();
  endfunction

  function automatic row_t step_row(logic [1:0] c, logic [31:0] a, logic [31:0] n, logic rb,
                                    logic [7:0] d, int nt = -1, act_t a0 = ACT_SELECT,
                                    logic [7:0] v0 = 8'h00, logic [31:0] i0 = 32'd0,
                                    act_t a1 = ACT_DESELECT);
    row_t w;
    w.req.cmd   = c;
    w.req.addr  = a;
    w.req.count = n;
    w.req.rdy   = rb;
    w.req.data  = d;
    w.n_typed   = nt;
    w.a0        = a0;
    w.v0        = v0;
    w.i0        = i0;
    w.a1        = a1;
    return w;
  endfunction

  // Mostly well-formed read runs; now and then a request the block must ignore
  function automatic req_t pick_request(bit noisy);
    req_t r;
    r.cmd   = 2'($urandom_range(0, 3));
    r.addr  = $urandom;
    r.count = $urandom;
    r.rdy   = 1'($urandom_range(0, 1));
    r.data  = 8'($urandom_range(0, 255));
    if (noisy && $urandom_range(0, 7) == 0) begin
      case (rd_phase)
        PH_WAIT: r.cmd = $urandom_range(0, 1) ? CMD_START : CMD_DATA;
        PH_READ: r.cmd = $urandom_range(0, 1) ? CMD_START : CMD_READY;
        default: r.cmd = $urandom_range(0, 1) ? CMD_READY : CMD_DATA;
      endcase
      if ($urandom_range(0, 2) == 0) r.cmd = CMD_UNUSED;
      return r;
    end
    case (rd_phase)
      PH_WAIT: begin
        r.cmd = CMD_READY;
        r.rdy = noisy ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
      PH_READ: r.cmd = CMD_DATA;
      default: begin
        r.cmd = CMD_START;
        // land near the end of a page so runs cross into the next one
        if ($urandom_range(0, 1))
          r.addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'(PAGE_BYTES - 1 - $urandom_range(0, 8));
        r.count = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
      end
    endcase
    return r;
  endfunction

  task automatic drive_request(req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.cmd           <= r.cmd;
    in_req.start_address <= r.addr;
    in_req.byte_count    <= r.count;
    in_req.ready_bit     <= r.rdy;
    in_req.flash_byte    <= r.data;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic issue(row_t w);
    drive_request(w.req);
    predict_actions(w.req);
    if (w.n_typed >= 0) begin
      step_actions.delete();
      if (w.n_typed > 0) add_action(w.a0, w.v0, w.i0);
      if (w.n_typed > 1) add_action(w.a1, 8'h00, 32'd0);
      close_step();
    end
    foreach (step_actions[k]) awaited_actions.push_back(step_actions[k]);
  endtask

  // Result side: random stall bursts until the final stretch
  initial begin
    out_res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (awaited_actions.size() == 0) begin
        errors++;
        $display("%0t: no result expected, got action=%0d value=%02h index=%0d last=%0b",
                 $time, out_res.action, out_res.bus_value, out_res.dest_index,
                 out_res.last_of_run);
      end else begin
        want = awaited_actions.pop_front();
        if (out_res.action !== want.action || out_res.bus_value !== want.value ||
            out_res.dest_index !== want.index || out_res.last_of_run !== want.last) begin
          errors++;
          $display("%0t: expected action=%0d value=%02h index=%0d last=%0b",
                   $time, want.action, want.value, want.index, want.last,
                   ", got action=%0d value=%02h index=%0d last=%0b",
                   out_res.action, out_res.bus_value, out_res.dest_index,
                   out_res.last_of_run);
        end
      end
    end
  end

  initial begin
    row_t plan[$];
    row_t w;
    int   useful;

    rst_n                <= 1'b0;
    in_req.valid         <= 1'b0;
    in_req.cmd           <= CMD_START;
    in_req.start_address <= '0;
    in_req.byte_count    <= '0;
    in_req.ready_bit     <= 1'b0;
    in_req.flash_byte    <= '0;

    // stray and unused requests from idle, empty starts
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 0));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'hff, 0));
    plan.push_back(step_row(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 8'hff, 0));
    plan.push_back(step_row(CMD_START, 32'd0, 32'd0, 1'b0, 8'h00, 2, ACT_SELECT, 8'h00,
                            32'd0, ACT_DESELECT));
    plan.push_back(step_row(CMD_START, 32'hffff_ffff, 32'd0, 1'b0, 8'h00, 2, ACT_SELECT,
                            8'h00, 32'd0, ACT_DESELECT));
    // three bytes across a page end, with busy and stray requests mixed in
    plan.push_back(step_row(CMD_START, 32'h0000_07fe, 32'd3, 1'b0, 8'h00));
    plan.push_back(step_row(CMD_START, 32'd0, 32'd5, 1'b0, 8'h00, 0));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b0, 8'h00, 0));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'h11, 0));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 1, ACT_STROBE));
    plan.push_back(step_row(CMD_START, 32'd0, 32'd1, 1'b0, 8'h00, 0));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 0));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'h00));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'hff));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 1, ACT_STROBE));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'ha5, 2, ACT_DATA, 8'ha5,
                            32'd2, ACT_DESELECT));
    // single byte run
    plan.push_back(step_row(CMD_START, 32'h0012_3456, 32'd1, 1'b0, 8'h00));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 1, ACT_STROBE));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'h5a, 2, ACT_DATA, 8'h5a,
                            32'd0, ACT_DESELECT));
    // closing rows: the longest run from the top address, wrapping to zero
    plan.push_back(step_row(CMD_START, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 8'h00));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b0, 8'h00, 0));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 1, ACT_STROBE));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'h81));
    plan.push_back(step_row(CMD_READY, 32'd0, 32'd0, 1'b1, 8'h00, 1, ACT_STROBE));
    plan.push_back(step_row(CMD_DATA, 32'd0, 32'd0, 1'b0, 8'h7e));
    plan.push_back(step_row(CMD_START, 32'd0, 32'd0, 1'b0, 8'h00, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < OPEN_ROWS; k++) issue(plan[k]);

    // keep going past the item target until the current run has ended
    useful = 0;
    while (useful < RAND_ITEMS || rd_phase != PH_IDLE) begin
      if (useful >= CALM_AFTER) calm = 1'b1;
      w = step_row(CMD_START, 32'd0, 32'd0, 1'b0, 8'h00);
      w.req = pick_request(useful < RAND_ITEMS);
      issue(w);
      if (step_actions.size() > 0) useful++;
    end

    for (int k = OPEN_ROWS; k < plan.size(); k++) issue(plan[k]);
    in_req.valid <= 1'b0;

    while (awaited_actions.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[nand_page_read_sequencer_top] OK");
    end else begin
      $display("[nand_page_read_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
